/* design/md5_pkg.sv */
// Package for the MD5 stream hasher: constants, round tables and state type.
// No dependencies; imported by md5_core and md5_stream_hasher.
package md5_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } md5_state_e;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    begin
      unique case ({i[5:4], i[1:0]})
        4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
        4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
        4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
        4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

  // Message word used by step i.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    begin
      unique case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: g = 4'(5 * i[3:0] + 1);
        2'd2: g = 4'(3 * i[3:0] + 5);
        default: g = 4'(7 * i[3:0]);
      endcase
      return g;
    end
  endfunction

endpackage

/* design/md5_stream_hasher.sv */
// MD5 over a byte stream: at most one byte per transaction, packed into a block RAM
// that md5_core compresses. Each transaction is written back to the RAM before the
// next is taken; after the 64th byte of a block the input stalls for the compression.
// End of message: the digest is valid after padding and the final compression,
// with a second compression when the length needs a second block.
// Asynchronous active-low reset restores the MD5 initial value, zero fill and
// zero length; the block RAM needs no clearing.
module md5_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // data_byte[7:0], byte_valid[8], zeros
  input  logic         s_axis_tlast_i,   // end_of_message
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // digest_low[63:0], digest_high[127:64]
);
  import md5_pkg::*;

  md5_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic        pad2_q, pad2_d;   // length goes into a second, zero block
  logic        ovalid_q, ovalid_d;
  logic [127:0] out_q;
  logic        start, clear, wr_en, busy, acc;
  logic [3:0]  wr_addr, pad_idx_q, pad_idx_d;
  logic [31:0] wr_data, rd_data, merged;
  logic [127:0] chain;
  logic [7:0]  byte_q;
  logic        last_q, bvalid_q;

  md5_core u_core (
    .clk_i, .rst_ni, .start_i(start), .clear_i(clear), .wr_en_i(wr_en),
    .wr_addr_i(wr_addr), .wr_data_i(wr_data), .rd_addr_i(fill_q[5:2]),
    .rd_data_o(rd_data), .busy_o(busy), .chain_o(chain)
  );

  assign acc = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE) & ~busy;

  // Merge byte into the word read back from the RAM at the current fill.
  always_comb begin
    merged = rd_data;
    unique case (fill_q[1:0])
      2'd0: merged = {24'd0, byte_q};
      2'd1: merged[15:8]  = byte_q;
      2'd2: merged[23:16] = byte_q;
      default: merged[31:24] = byte_q;
    endcase
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; len_d = len_q; pad2_d = pad2_q;
    ovalid_d = ovalid_q; pad_idx_d = pad_idx_q;
    start = 1'b0; clear = 1'b0; wr_en = 1'b0; wr_addr = fill_q[5:2]; wr_data = merged;
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // RAM read of the target word has landed; write the byte back
        if (bvalid_q) begin
          wr_en = 1'b1;
          len_d = len_q + 64'd8;
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            start = 1'b1;
          end
        end
        if (last_q) begin
          state_d = ST_FOLD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FOLD: begin
        // wait for compression, then put the 0x80 marker after a fresh read
        if (!busy) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_PAD;
      end
      ST_PAD: begin
        wr_en = 1'b1;
        wr_addr = fill_q[5:2];
        unique case (fill_q[1:0])
          2'd0: wr_data = 32'h0000_0080;
          2'd1: wr_data = {16'd0, 8'h80, rd_data[7:0]};
          2'd2: wr_data = {8'd0, 8'h80, rd_data[15:0]};
          default: wr_data = {8'h80, rd_data[23:0]};
        endcase
        pad2_d = (fill_q >= 6'd56);
        pad_idx_d = fill_q[5:2] + 4'd1;
        state_d = ST_OUT;
        if (fill_q[5:2] == 4'd15) begin
          // marker fills the last word: compress now, length goes in a second block
          start = 1'b1;
          pad_idx_d = 4'd0;
        end
      end
      default: begin
        // ST_OUT: zero the rest, place the length, compress; twice if needed
        if (!busy) begin
          if (pad_idx_q != 4'd0) begin
            wr_en = 1'b1;
            wr_addr = pad_idx_q;
            wr_data = '0;
            if (!pad2_q && pad_idx_q == 4'd14) wr_data = len_q[31:0];
            if (!pad2_q && pad_idx_q == 4'd15) wr_data = len_q[63:32];
            pad_idx_d = pad_idx_q + 4'd1;
            if (pad_idx_q == 4'd15) begin
              start = 1'b1;
              pad_idx_d = 4'd0;
            end
          end else if (pad2_q) begin
            // second block of zeros with the length
            wr_en = 1'b1; wr_addr = 4'd0; wr_data = '0;
            pad2_d = 1'b0; pad_idx_d = 4'd1;
          end else if (!ovalid_q || m_axis_tready_i) begin
            ovalid_d = 1'b1;
            clear = 1'b1;
            fill_d = '0; len_d = '0;
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; fill_q <= '0; len_q <= '0; pad2_q <= 1'b0;
      ovalid_q <= 1'b0; pad_idx_q <= '0; bvalid_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; len_q <= len_d; pad2_q <= pad2_d;
      ovalid_q <= ovalid_d; pad_idx_q <= pad_idx_d;
      if (acc) begin
        bvalid_q <= s_axis_tdata_i[8]; last_q <= s_axis_tlast_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      byte_q <= s_axis_tdata_i[7:0];
    end
    if (clear) begin
      out_q <= chain;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;
endmodule

/* design/md5_core.sv */
// MD5 compression: one step per cycle over a block held in a synchronous RAM.
// Depends on md5_pkg. Word reads issue in the cycle before the step that uses them.
module md5_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,     // begin compression of the stored block
  input  logic        clear_i,     // restore the initial chaining value
  input  logic        wr_en_i,     // block RAM write port
  input  logic [3:0]  wr_addr_i,
  input  logic [31:0] wr_data_i,
  input  logic [3:0]  rd_addr_i,   // block RAM read port while idle
  output logic [31:0] rd_data_o,
  output logic        busy_o,
  output logic [127:0] chain_o
);
  import md5_pkg::*;

  logic [31:0] mem_q [16];
  logic [31:0] rd_q;
  logic        run_q, run_d;
  logic        pre_q, pre_d;   // read of the first word in flight
  logic        fold_q, fold_d;
  logic [5:0]  step_q, step_d;
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [127:0] cv_q, cv_d;
  logic [3:0]  raddr;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;

  always_comb begin
    if (pre_q || run_q) begin
      raddr = word_index(pre_q ? step_q : 6'(step_q + 6'd1));
    end else begin
      raddr = rd_addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[raddr];
  end

  assign rd_data_o = rd_q;

  always_comb begin
    unique case (step_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = f + a_q + sine_k(step_q) + rd_q;
    sh  = rot_amount(step_q);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    run_d = run_q; pre_d = 1'b0; fold_d = 1'b0; step_d = step_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; cv_d = cv_q;
    if (clear_i) begin
      cv_d = {IvD, IvC, IvB, IvA};
    end
    if (start_i) begin
      pre_d = 1'b1; step_d = '0;
      a_d = cv_q[31:0]; b_d = cv_q[63:32]; c_d = cv_q[95:64]; d_d = cv_q[127:96];
    end
    if (pre_q) begin
      run_d = 1'b1;
    end
    if (run_q) begin
      a_d = d_q; d_d = c_q; c_d = b_q; b_d = b_q + rot;
      step_d = step_q + 6'd1;
      if (step_q == 6'd63) begin
        run_d = 1'b0; fold_d = 1'b1;
      end
    end
    if (fold_q) begin
      cv_d = {cv_q[127:96] + d_q, cv_q[95:64] + c_q, cv_q[63:32] + b_q, cv_q[31:0] + a_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; pre_q <= 1'b0; fold_q <= 1'b0; step_q <= '0;
      cv_q <= {IvD, IvC, IvB, IvA};
    end else begin
      run_q <= run_d; pre_q <= pre_d; fold_q <= fold_d; step_q <= step_d;
      cv_q <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
  end

  assign busy_o  = run_q | pre_q | fold_q;
  assign chain_o = cv_q;
endmodule

/* bench/tb_md5_stream_hasher.sv */
// Self-checking bench for md5_stream_hasher: byte stream in, 128-bit digest out.
// Carries its own MD5 predictor; depends only on the DUT (no package functions).
module tb_md5_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [15:0]  s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;

  md5_stream_hasher DUT (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] chain_q [4];
  logic [31:0] words_q [16];
  int unsigned fill_q;
  logic [63:0] bits_q;

  byte_item_t  pending_items [$];
  logic [127:0] expected_digests [$];
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_sender;
  int unsigned failures, digests_seen, cycle_count, bytes_sent;

  localparam logic [31:0] KTab [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int ShiftTab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  task automatic md5_init();
    chain_q = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    foreach (words_q[i]) words_q[i] = '0;
    fill_q = 0;
    bits_q = '0;
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g, r;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      f = f + a + KTab[i] + words_q[g];
      t = (f << ShiftTab[r * 4 + i % 4]) | (f >> (32 - ShiftTab[r * 4 + i % 4]));
      a = d; d = c; c = b; b = b + t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endtask

  task automatic md5_put(input logic [7:0] value);
    words_q[fill_q / 4][(fill_q % 4) * 8 +: 8] = value;
    fill_q++;
    if (fill_q == 64) begin
      md5_compress();
      fill_q = 0;
    end
  endtask

  // Advance the predictor by one accepted transaction.
  task automatic md5_absorb(input byte_item_t it);
    logic [63:0] len;
    if (it.byte_valid) begin
      bits_q += 64'd8;
      md5_put(it.data_byte);
    end
    if (it.end_of_message) begin
      len = bits_q;
      md5_put(8'h80);
      if (fill_q > 56) while (fill_q != 0) md5_put(8'h00);
      while (fill_q < 56) md5_put(8'h00);
      words_q[14] = len[31:0];
      words_q[15] = len[63:32];
      md5_compress();
      expected_digests.push_back({chain_q[3], chain_q[2], chain_q[1], chain_q[0]});
      md5_init();
    end
  endtask

  function automatic byte_item_t mk(input logic [7:0] db, input bit v, input bit e);
    byte_item_t it;
    it.data_byte = db; it.byte_valid = v; it.end_of_message = e;
    return it;
  endfunction

  // Queue one message of n bytes; last byte may carry the end flag or not.
  task automatic queue_message(input int n, input bit noise);
    bit end_on_byte;
    end_on_byte = (n > 0) && $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        pending_items.push_back(mk(8'($urandom), 1'b0, 1'b0));
      pending_items.push_back(mk(8'($urandom), 1'b1, end_on_byte && i == n - 1));
    end
    if (!end_on_byte) pending_items.push_back(mk(8'($urandom), 1'b0, 1'b1));
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        md5_absorb(byte_item_t'({s_axis_tdata_i[7:0], s_axis_tdata_i[8], s_axis_tlast_i}));
        bytes_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_items.size() > 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          byte_item_t it;
          it = pending_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {7'd0, it.byte_valid, it.data_byte};
          s_axis_tlast_i  <= it.end_of_message;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      logic [127:0] exp_d;
      digests_seen++;
      if (expected_digests.size() == 0) begin
        $error("unexpected digest %h", m_axis_tdata_o);
        failures++;
      end else begin
        exp_d = expected_digests.pop_front();
        if (m_axis_tdata_o[63:0] !== exp_d[63:0]) begin
          $error("digest_low expected %h actual %h", exp_d[63:0], m_axis_tdata_o[63:0]);
          failures++;
        end
        if (m_axis_tdata_o[127:64] !== exp_d[127:64]) begin
          $error("digest_high expected %h actual %h", exp_d[127:64], m_axis_tdata_o[127:64]);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 600000) begin
      $display("timeout with %0d digests outstanding", expected_digests.size());
      $display("tb_md5_stream_hasher failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid_i || expected_digests.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int lens [];
    lens = '{0, 1, 3, 55, 56, 57, 63, 64, 65, 119, 120};
    md5_init();
    send_idle_pct = 11;
    recv_idle_pct = 74;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, byte extremes, idle noise, pad boundary lengths
    pending_items.push_back(mk(8'h00, 1'b0, 1'b0));
    pending_items.push_back(mk(8'hff, 1'b0, 1'b1));
    pending_items.push_back(mk(8'h00, 1'b1, 1'b0));
    pending_items.push_back(mk(8'hff, 1'b1, 1'b1));
    pending_items.push_back(mk(8'haa, 1'b1, 1'b0));
    pending_items.push_back(mk(8'h55, 1'b0, 1'b0));
    pending_items.push_back(mk(8'h55, 1'b1, 1'b0));
    pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
    foreach (lens[i]) queue_message(lens[i], 1'b0);

    // Random messages, mostly short, some crossing block edges, in three idle phases
    for (int phase = 0; phase < 3; phase++) begin
      for (int m = 0; m < 12; m++) begin
        if ($urandom_range(0, 9) == 0) queue_message($urandom_range(50, 140), 1'b1);
        else queue_message($urandom_range(0, 12), 1'b1);
      end
      drain();
      if (phase == 0) begin
        // Hold the sender while one message is queued, then release it and drain
        hold_sender = 1'b1;
        queue_message(57, 1'b0);
        repeat (3) @(posedge clk_i);
        hold_sender = 1'b0;
        drain();
        send_idle_pct = 74; recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
    end
    repeat (300) @(posedge clk_i);
    $display("Streamed %0d transactions, checked %0d digests,", bytes_sent, digests_seen);
    $display("including empty and pad-boundary messages under three idle mixes.");
    if (failures == 0 && expected_digests.size() == 0) begin
      $display("tb_md5_stream_hasher passed");
    end else begin
      $display("tb_md5_stream_hasher failed");
    end
    $finish;
  end
endmodule

/* md5_stream_hasher.f */
design/md5_pkg.sv
design/md5_core.sv
design/md5_stream_hasher.sv
bench/tb_md5_stream_hasher.sv
